// File: rtl/dmm_pkg.sv
// ----------------------------------------------------------------------------
// dmm_pkg
// shared types, codes and defaults of the delayed message mailbox
// ----------------------------------------------------------------------------
package dmm_pkg;

  localparam int unsigned DefQueueDepth    = 16;
  localparam int unsigned DefNumCtrl       = 4;
  localparam int unsigned DefPayloadBits   = 32;
  localparam int unsigned DefLatencyBits   = 8;

  localparam int unsigned IdW       = 2;
  localparam int unsigned FieldLatW = 8;
  localparam int unsigned FieldPayW = 32;
  localparam int unsigned ApbAddrW  = 5;
  localparam int unsigned ApbDataW  = 32;
  localparam logic [FieldLatW-1:0] DefaultLatencyReset = 8'd1;

  typedef enum logic [1:0] {
    FUNC_SEND = 2'd0,
    FUNC_RECV = 2'd1,
    FUNC_TICK = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FOUND     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    REG_DEFAULT_LAT = 3'd0,
    REG_PAIR_MASK   = 3'd1,
    REG_PAIR_ROW0   = 3'd2,
    REG_PAIR_ROW1   = 3'd3,
    REG_PAIR_ROW2   = 3'd4,
    REG_PAIR_ROW3   = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic           send;
    logic           recv;
    logic           tick;
    logic [IdW-1:0] dest;
  } cell_ctrl_t;

  typedef struct packed {
    logic [FieldLatW-1:0] default_lat;
    logic [15:0]          pair_mask;
    logic [3:0][31:0]     pair_rows;
  } cfg_t;

endpackage

// File: rtl/dmm_if.sv
// ----------------------------------------------------------------------------
// dmm_req_if / dmm_rsp_if
// valid/ready channels carrying mailbox requests and responses
// ----------------------------------------------------------------------------
interface dmm_req_if;
  import dmm_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [1:0]           func;
  logic [IdW-1:0]       src_id;
  logic [IdW-1:0]       dest_id;
  logic                 use_default_latency;
  logic [FieldLatW-1:0] explicit_latency;
  logic [FieldPayW-1:0] payload;

  modport source (
    output valid, func, src_id, dest_id, use_default_latency, explicit_latency, payload,
    input  ready
  );
  modport sink (
    input  valid, func, src_id, dest_id, use_default_latency, explicit_latency, payload,
    output ready
  );
endinterface

interface dmm_rsp_if;
  import dmm_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [1:0]           status;
  logic [IdW-1:0]       found_src;
  logic [IdW-1:0]       found_dest;
  logic [FieldPayW-1:0] found_payload;

  modport source (
    output valid, status, found_src, found_dest, found_payload,
    input  ready
  );
  modport sink (
    input  valid, status, found_src, found_dest, found_payload,
    output ready
  );
endinterface

// File: rtl/delayed_message_mailbox.sv
// ----------------------------------------------------------------------------
// delayed_message_mailbox
// ordered store of delayed messages between controllers, built as a row of slots
// ----------------------------------------------------------------------------
//   channel  dir  handshake       contents
//   req_i    in   valid/ready     func, src_id, dest_id, latency select, payload
//   rsp_o    out  valid/ready     status, found_src, found_dest, found_payload
//   apb      in   psel/penable    register writes and reads, pready tied high
//
// every request completes when it is accepted; the response register holds the result
// a new request is taken whenever the response register is empty or being read
// a stalled response stalls only the request channel
// reset empties every slot and loads the register defaults
// ----------------------------------------------------------------------------
module delayed_message_mailbox #(
  parameter int unsigned QUEUE_DEPTH     = dmm_pkg::DefQueueDepth,
  parameter int unsigned NUM_CONTROLLERS = dmm_pkg::DefNumCtrl,
  parameter int unsigned PAYLOAD_BITS    = dmm_pkg::DefPayloadBits,
  parameter int unsigned LATENCY_BITS    = dmm_pkg::DefLatencyBits
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  dmm_req_if.sink                      req_i,
  dmm_rsp_if.source                    rsp_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dmm_pkg::ApbAddrW-1:0] paddr,
  input  logic [dmm_pkg::ApbDataW-1:0] pwdata,
  output logic [dmm_pkg::ApbDataW-1:0] prdata,
  output logic                         pready
);
  import dmm_pkg::*;

  localparam int unsigned SW = (PAYLOAD_BITS < FieldPayW) ? PAYLOAD_BITS : FieldPayW;
  localparam int unsigned LW = LATENCY_BITS;
  localparam logic [15:0] LatMax = 16'((32'd1 << LW) - 32'd1);
  localparam logic [IdW:0] NumCtrl = (IdW+1)'(NUM_CONTROLLERS);

  cfg_t       cfg;
  cell_ctrl_t ctrl;
  logic       accept;
  func_e      func;

  logic [QUEUE_DEPTH:0]          c_valid;
  logic [IdW-1:0]                c_src  [QUEUE_DEPTH+1];
  logic [IdW-1:0]                c_dest [QUEUE_DEPTH+1];
  logic [LW-1:0]                 c_cd   [QUEUE_DEPTH+1];
  logic [SW-1:0]                 c_pay  [QUEUE_DEPTH+1];
  logic [QUEUE_DEPTH:0]          older;
  logic [QUEUE_DEPTH-1:0]        sel;
  logic [QUEUE_DEPTH-1:0]        valid_vec;

  logic                 pair_on;
  logic [7:0]           pair_lat, raw_lat;
  logic [15:0]          lat_ext, lat_sat;
  logic [LW-1:0]        new_cd;
  logic [SW-1:0]        new_pay;

  logic [IdW-1:0] sel_src, sel_dest;
  logic [SW-1:0]  sel_pay;
  logic           found, full;

  logic                 out_valid_q;
  status_e              status_q, status_d;
  logic [IdW-1:0]       fsrc_q, fdest_q;
  logic [FieldPayW-1:0] fpay_q, fpay_d;

  dmm_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign req_i.ready = !out_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;
  assign func        = func_e'(req_i.func);

  assign ctrl.send = accept && (func == FUNC_SEND);
  assign ctrl.recv = accept && (func == FUNC_RECV);
  assign ctrl.tick = accept && (func == FUNC_TICK);
  assign ctrl.dest = req_i.dest_id;

  // latency of a new message
  assign pair_on  = ({1'b0, req_i.src_id} < NumCtrl) && ({1'b0, req_i.dest_id} < NumCtrl)
                    && cfg.pair_mask[{req_i.src_id, req_i.dest_id}];
  assign pair_lat = 8'(cfg.pair_rows[req_i.src_id] >> {req_i.dest_id, 3'b000});
  always_comb begin
    if (!req_i.use_default_latency) raw_lat = req_i.explicit_latency;
    else if (pair_on)                raw_lat = pair_lat;
    else                             raw_lat = cfg.default_lat;
    lat_ext = {8'd0, raw_lat};
    lat_sat = (lat_ext > LatMax) ? LatMax : lat_ext;
  end
  assign new_cd  = lat_sat[LW-1:0];
  assign new_pay = req_i.payload[SW-1:0];

  assign older[0]            = 1'b0;
  assign c_valid[QUEUE_DEPTH] = 1'b0;
  assign c_src[QUEUE_DEPTH]   = '0;
  assign c_dest[QUEUE_DEPTH]  = '0;
  assign c_cd[QUEUE_DEPTH]    = '0;
  assign c_pay[QUEUE_DEPTH]   = '0;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic prev_v;
    if (i == 0) begin : g_head
      assign prev_v = 1'b1;
    end else begin : g_body
      assign prev_v = c_valid[i-1];
    end
    dmm_cell #(.LW(LW), .PW(SW)) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .new_src_i    (req_i.src_id),
      .new_cd_i     (new_cd),
      .new_pay_i    (new_pay),
      .prev_valid_i (prev_v),
      .older_hit_i  (older[i]),
      .next_valid_i (c_valid[i+1]),
      .next_src_i   (c_src[i+1]),
      .next_dest_i  (c_dest[i+1]),
      .next_cd_i    (c_cd[i+1]),
      .next_pay_i   (c_pay[i+1]),
      .valid_o      (c_valid[i]),
      .src_o        (c_src[i]),
      .dest_o       (c_dest[i]),
      .cd_o         (c_cd[i]),
      .pay_o        (c_pay[i]),
      .older_hit_o  (older[i+1]),
      .sel_o        (sel[i])
    );
  end

  assign valid_vec = c_valid[QUEUE_DEPTH-1:0];
  assign found     = older[QUEUE_DEPTH];
  assign full      = c_valid[QUEUE_DEPTH-1];

  // one-hot pick of the matched slot
  always_comb begin
    sel_src  = '0;
    sel_dest = '0;
    sel_pay  = '0;
    for (int unsigned k = 0; k < QUEUE_DEPTH; k++) begin
      sel_src  = sel_src  | (c_src[k]  & {IdW{sel[k]}});
      sel_dest = sel_dest | (c_dest[k] & {IdW{sel[k]}});
      sel_pay  = sel_pay  | (c_pay[k]  & {SW{sel[k]}});
    end
  end

  always_comb begin
    status_d = ST_OK;
    fpay_d   = '0;
    case (func)
      FUNC_SEND: status_d = full ? ST_FULL : ST_OK;
      FUNC_RECV: status_d = found ? ST_FOUND : ST_NOT_FOUND;
      FUNC_TICK: status_d = ST_OK;
      default:   status_d = ST_OK;
    endcase
    if (func == FUNC_RECV && found) begin
      fpay_d[SW-1:0] = sel_pay;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      fsrc_q   <= (func == FUNC_RECV && found) ? sel_src  : '0;
      fdest_q  <= (func == FUNC_RECV && found) ? sel_dest : '0;
      fpay_q   <= fpay_d;
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.status        = status_q;
  assign rsp_o.found_src     = fsrc_q;
  assign rsp_o.found_dest    = fdest_q;
  assign rsp_o.found_payload = fpay_q;

`ifndef NO_ASSERTIONS
  a_valid_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((valid_vec + QUEUE_DEPTH'(1)) & valid_vec) == '0)
    else $error("occupied slots are not a prefix");

  a_single_pick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(sel))
    else $error("more than one slot selected");

  a_full_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.send && full |=> status_q == ST_FULL && $stable(valid_vec))
    else $error("send to a full store not dropped");

  a_recv_removes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.recv && found |=> $countones(valid_vec) + 1 == $past($countones(valid_vec)))
    else $error("receive did not remove exactly one slot");

  a_send_adds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.send && !full |=> $countones(valid_vec) == $past($countones(valid_vec)) + 1)
    else $error("send did not add exactly one slot");
`endif

endmodule

// File: rtl/dmm_cfg_regs.sv
// ----------------------------------------------------------------------------
// dmm_cfg_regs
// apb register file: default latency, pair mask and pair latency rows
// ----------------------------------------------------------------------------
module dmm_cfg_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [dmm_pkg::ApbAddrW-1:0]      paddr,
  input  logic [dmm_pkg::ApbDataW-1:0]      pwdata,
  output logic [dmm_pkg::ApbDataW-1:0]      prdata,
  output logic                              pready,
  output dmm_pkg::cfg_t                     cfg_o
);
  import dmm_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[ApbAddrW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.default_lat <= DefaultLatencyReset;
      cfg_q.pair_mask   <= '0;
      cfg_q.pair_rows   <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_DEFAULT_LAT: cfg_q.default_lat  <= pwdata[FieldLatW-1:0];
        REG_PAIR_MASK:   cfg_q.pair_mask    <= pwdata[15:0];
        REG_PAIR_ROW0:   cfg_q.pair_rows[0] <= pwdata;
        REG_PAIR_ROW1:   cfg_q.pair_rows[1] <= pwdata;
        REG_PAIR_ROW2:   cfg_q.pair_rows[2] <= pwdata;
        REG_PAIR_ROW3:   cfg_q.pair_rows[3] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_DEFAULT_LAT: prdata = {{(ApbDataW-FieldLatW){1'b0}}, cfg_q.default_lat};
      REG_PAIR_MASK:   prdata = {16'd0, cfg_q.pair_mask};
      REG_PAIR_ROW0:   prdata = cfg_q.pair_rows[0];
      REG_PAIR_ROW1:   prdata = cfg_q.pair_rows[1];
      REG_PAIR_ROW2:   prdata = cfg_q.pair_rows[2];
      REG_PAIR_ROW3:   prdata = cfg_q.pair_rows[3];
      default:         prdata = '0;
    endcase
  end

endmodule

// File: rtl/dmm_cell.sv
// ----------------------------------------------------------------------------
// dmm_cell
// one mailbox slot: appends, counts down and closes up from its younger neighbor
// ----------------------------------------------------------------------------
module dmm_cell #(
  parameter int unsigned LW = 8,
  parameter int unsigned PW = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  dmm_pkg::cell_ctrl_t     ctrl_i,
  input  logic [dmm_pkg::IdW-1:0] new_src_i,
  input  logic [LW-1:0]           new_cd_i,
  input  logic [PW-1:0]           new_pay_i,
  input  logic                    prev_valid_i,
  input  logic                    older_hit_i,
  input  logic                    next_valid_i,
  input  logic [dmm_pkg::IdW-1:0] next_src_i,
  input  logic [dmm_pkg::IdW-1:0] next_dest_i,
  input  logic [LW-1:0]           next_cd_i,
  input  logic [PW-1:0]           next_pay_i,
  output logic                    valid_o,
  output logic [dmm_pkg::IdW-1:0] src_o,
  output logic [dmm_pkg::IdW-1:0] dest_o,
  output logic [LW-1:0]           cd_o,
  output logic [PW-1:0]           pay_o,
  output logic                    older_hit_o,
  output logic                    sel_o
);
  import dmm_pkg::*;

  logic           valid_q;
  logic [IdW-1:0] src_q, dest_q;
  logic [LW-1:0]  cd_q;
  logic [PW-1:0]  pay_q;
  logic           hit, load, shift;

  assign hit         = valid_q && (dest_q == ctrl_i.dest) && (cd_q == '0);
  assign older_hit_o = older_hit_i || hit;
  assign sel_o       = hit && !older_hit_i;
  assign load        = ctrl_i.send && prev_valid_i && !valid_q;
  assign shift       = ctrl_i.recv && (older_hit_i || hit);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (shift) begin
      valid_q <= next_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      src_q  <= new_src_i;
      dest_q <= ctrl_i.dest;
      cd_q   <= new_cd_i;
      pay_q  <= new_pay_i;
    end else if (shift) begin
      src_q  <= next_src_i;
      dest_q <= next_dest_i;
      cd_q   <= next_cd_i;
      pay_q  <= next_pay_i;
    end else if (ctrl_i.tick && valid_q && cd_q != '0) begin
      cd_q <= cd_q - LW'(1);
    end
  end

  assign valid_o = valid_q;
  assign src_o   = src_q;
  assign dest_o  = dest_q;
  assign cd_o    = cd_q;
  assign pay_o   = pay_q;

endmodule
